/* src/lspf_pkg.sv */
// Shared types, codes and matrix-entry lookup for the least-squares plane fit.
// No dependencies.
package lspf_pkg;

  typedef struct packed {
    logic signed [19:0] coord_x;
    logic signed [19:0] coord_y;
    logic signed [19:0] coord_z;
    logic               last_atom;
  } atom_t;

  typedef struct packed {
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] offset;
    logic        [1:0]  fit_status;
  } fit_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // operand codes
  localparam logic [3:0] E_SXX = 4'd0;
  localparam logic [3:0] E_SXY = 4'd1;
  localparam logic [3:0] E_SX  = 4'd2;
  localparam logic [3:0] E_SYY = 4'd3;
  localparam logic [3:0] E_SY  = 4'd4;
  localparam logic [3:0] E_N   = 4'd5;
  localparam logic [3:0] E_SXZ = 4'd6;
  localparam logic [3:0] E_SYZ = 4'd7;
  localparam logic [3:0] E_SZ  = 4'd8;

  localparam logic [1:0] COL_NONE = 2'd3;

  typedef struct packed {
    logic       acc;
    logic       mload;
    logic       mstep;
    logic       mcommit;
    logic [3:0] x_code;
    logic [3:0] y_code;
    logic       x_is_t;
    logic       tgt_d;
    logic       first;
    logic       neg;
    logic       clr_d;
    logic       det_save;
    logic       dload;
    logic       sh8;
    logic       dstep;
    logic       dfin;
    logic [1:0] col;
    logic       emit;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic det_zero;
  } stat_t;

  // entry (row, col) of the normal matrix with column sub replaced by the rhs
  function automatic logic [3:0] entry_code(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] sub);
    logic [3:0] code;
    code = E_N;
    if (c == sub) begin
      unique case (r)
        2'd0:    code = E_SXZ;
        2'd1:    code = E_SYZ;
        default: code = E_SZ;
      endcase
    end else begin
      unique case ({r, c})
        4'b0000: code = E_SXX;
        4'b0001: code = E_SXY;
        4'b0010: code = E_SX;
        4'b0100: code = E_SXY;
        4'b0101: code = E_SYY;
        4'b0110: code = E_SY;
        4'b1000: code = E_SX;
        4'b1001: code = E_SY;
        default: code = E_N;
      endcase
    end
    return code;
  endfunction

endpackage

/* src/lspf_datapath.sv */
// Datapath: running sums, bit-serial wide multiplier, determinant accumulator,
// restoring divider with round and saturate. Depends on lspf_pkg.
module lspf_datapath #(
  parameter int MAX_ATOMS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  lspf_pkg::atom_t atom,
  input  lspf_pkg::cmd_t  cmd,
  output lspf_pkg::stat_t stat,
  output logic            done,
  output lspf_pkg::fit_t  result
);
  localparam int N_W    = $clog2(MAX_ATOMS + 1);
  localparam int SUM1_W = 20 + N_W;
  localparam int SUM2_W = 40 + N_W;
  localparam int WW     = 3 * SUM2_W + 18;

  logic signed [SUM1_W-1:0] sx, sy, sz;
  logic signed [SUM2_W-1:0] sxx, syy, sxy, sxz, syz;
  logic [N_W-1:0]           cnt;
  logic                     ovf;

  logic signed [39:0] pxx, pyy, pxy, pxz, pyz;
  assign pxx = atom.coord_x * atom.coord_x;
  assign pyy = atom.coord_y * atom.coord_y;
  assign pxy = atom.coord_x * atom.coord_y;
  assign pxz = atom.coord_x * atom.coord_z;
  assign pyz = atom.coord_y * atom.coord_z;

  function automatic logic signed [SUM2_W-1:0] sel_entry(input logic [3:0] code);
    logic signed [SUM2_W-1:0] v;
    unique case (code)
      lspf_pkg::E_SXX: v = sxx;
      lspf_pkg::E_SXY: v = sxy;
      lspf_pkg::E_SX:  v = {{(SUM2_W-SUM1_W){sx[SUM1_W-1]}}, sx};
      lspf_pkg::E_SYY: v = syy;
      lspf_pkg::E_SY:  v = {{(SUM2_W-SUM1_W){sy[SUM1_W-1]}}, sy};
      lspf_pkg::E_SXZ: v = sxz;
      lspf_pkg::E_SYZ: v = syz;
      lspf_pkg::E_SZ:  v = {{(SUM2_W-SUM1_W){sz[SUM1_W-1]}}, sz};
      default:         v = {{(SUM2_W-N_W){1'b0}}, cnt};
    endcase
    return v;
  endfunction

  logic signed [SUM2_W-1:0] ex, ey;
  assign ex = sel_entry(cmd.x_code);
  assign ey = sel_entry(cmd.y_code);

  logic signed [WW-1:0] mcand, prod, t, dacc, det, addend;
  logic [SUM2_W-1:0]    mplier;
  logic                 mneg;

  assign addend = mneg ? -prod : prod;

  // divider
  logic [WW-1:0]   nmag, dmag, q, qr;
  logic [WW-1:0]   r;
  logic [WW:0]     rs;
  logic            dneg, qbit, rnd;
  logic signed [WW-1:0] num;
  logic [31:0]     sat;
  logic [31:0]     res [3];

  assign num  = cmd.sh8 ? (dacc <<< 8) : (dacc <<< 16);
  assign rs   = {r, nmag[WW-1]};
  assign qbit = rs >= {1'b0, dmag};
  assign rnd  = {r, 1'b0} >= {1'b0, dmag};
  assign qr   = q + {{(WW-1){1'b0}}, rnd};

  always_comb begin
    if (dneg) begin
      sat = (|qr[WW-1:31]) ? 32'h8000_0000 : -qr[31:0];
    end else begin
      sat = (|qr[WW-1:31]) ? 32'h7FFF_FFFF : qr[31:0];
    end
  end

  assign stat.ovf      = ovf;
  assign stat.det_zero = (dacc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; sz <= '0;
      sxx <= '0; syy <= '0; sxy <= '0; sxz <= '0; syz <= '0;
      cnt <= '0;
      ovf <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.emit) begin
        sx <= '0; sy <= '0; sz <= '0;
        sxx <= '0; syy <= '0; sxy <= '0; sxz <= '0; syz <= '0;
        cnt <= '0;
        ovf <= 1'b0;
      end else if (cmd.acc) begin
        if (cnt == N_W'(MAX_ATOMS)) begin
          ovf <= 1'b1;
        end else begin
          sx  <= sx + {{(SUM1_W-20){atom.coord_x[19]}}, atom.coord_x};
          sy  <= sy + {{(SUM1_W-20){atom.coord_y[19]}}, atom.coord_y};
          sz  <= sz + {{(SUM1_W-20){atom.coord_z[19]}}, atom.coord_z};
          sxx <= sxx + {{(SUM2_W-40){pxx[39]}}, pxx};
          syy <= syy + {{(SUM2_W-40){pyy[39]}}, pyy};
          sxy <= sxy + {{(SUM2_W-40){pxy[39]}}, pxy};
          sxz <= sxz + {{(SUM2_W-40){pxz[39]}}, pxz};
          syz <= syz + {{(SUM2_W-40){pyz[39]}}, pyz};
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mload) begin
      mcand  <= cmd.x_is_t ? t : {{(WW-SUM2_W){ex[SUM2_W-1]}}, ex};
      mplier <= ey[SUM2_W-1] ? -ey : ey;
      mneg   <= cmd.neg ^ ey[SUM2_W-1];
      prod   <= '0;
      if (cmd.clr_d) begin
        dacc <= '0;
      end
    end
    if (cmd.mstep) begin
      prod   <= (prod <<< 1) + (mplier[SUM2_W-1] ? mcand : '0);
      mplier <= mplier << 1;
    end
    if (cmd.mcommit) begin
      if (cmd.tgt_d) begin
        dacc <= dacc + addend;
      end else begin
        t <= (cmd.first ? '0 : t) + addend;
      end
    end
    if (cmd.det_save) begin
      det <= dacc;
    end
    if (cmd.dload) begin
      nmag <= num[WW-1] ? -num : num;
      dmag <= det[WW-1] ? -det : det;
      dneg <= num[WW-1] ^ det[WW-1];
      r    <= '0;
      q    <= '0;
    end
    if (cmd.dstep) begin
      r    <= qbit ? WW'(rs - {1'b0, dmag}) : rs[WW-1:0];
      q    <= {q[WW-2:0], qbit};
      nmag <= nmag << 1;
    end
    if (cmd.dfin) begin
      res[cmd.col] <= sat;
    end
    if (cmd.emit) begin
      result.fit_status <= cmd.status;
      if (cmd.status == lspf_pkg::ST_OK) begin
        result.slope_x <= res[0];
        result.slope_y <= res[1];
        result.offset  <= res[2];
      end else begin
        result.slope_x <= '0;
        result.slope_y <= '0;
        result.offset  <= '0;
      end
    end
  end

endmodule

/* src/lspf_ctrl.sv */
// Controller: sequences accumulation, the four 3x3 determinants, the three
// divisions and the result transaction. Depends on lspf_pkg.
module lspf_ctrl #(
  parameter int MAX_ATOMS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last_atom,
  input  lspf_pkg::stat_t stat,
  output logic            busy,
  output lspf_pkg::cmd_t  cmd
);
  localparam int N_W    = $clog2(MAX_ATOMS + 1);
  localparam int SUM2_W = 40 + N_W;
  localparam int WW     = 3 * SUM2_W + 18;
  localparam int C_W    = $clog2(WW);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_MLOAD   = 4'd2;
  localparam logic [3:0] S_MSTEP   = 4'd3;
  localparam logic [3:0] S_MCOMMIT = 4'd4;
  localparam logic [3:0] S_DETDONE = 4'd5;
  localparam logic [3:0] S_DLOAD   = 4'd6;
  localparam logic [3:0] S_DSTEP   = 4'd7;
  localparam logic [3:0] S_DFIN    = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]     state;
  logic [1:0]     k, p, col, status;
  logic [C_W-1:0] bitcnt;
  logic [1:0]     c1, c2;

  assign busy = (state != S_IDLE);
  assign c1 = (k == 2'd0) ? 2'd1 : 2'd0;
  assign c2 = (k == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    cmd          = '0;
    cmd.acc      = (state == S_IDLE) && start;
    cmd.mload    = (state == S_MLOAD);
    cmd.mstep    = (state == S_MSTEP);
    cmd.mcommit  = (state == S_MCOMMIT);
    cmd.x_is_t   = (p == 2'd2);
    cmd.tgt_d    = (p == 2'd2);
    cmd.first    = (p == 2'd0);
    cmd.neg      = (p == 2'd1) || ((p == 2'd2) && (k == 2'd1));
    cmd.clr_d    = (k == 2'd0) && (p == 2'd0);
    cmd.det_save = (state == S_DETDONE) && (col == lspf_pkg::COL_NONE);
    cmd.dload    = (state == S_DLOAD);
    cmd.sh8      = (col == 2'd2);
    cmd.dstep    = (state == S_DSTEP);
    cmd.dfin     = (state == S_DFIN);
    cmd.col      = col;
    cmd.emit     = (state == S_EMIT);
    cmd.status   = status;
    unique case (p)
      2'd0: begin
        cmd.x_code = lspf_pkg::entry_code(2'd2, c2, col);
        cmd.y_code = lspf_pkg::entry_code(2'd1, c1, col);
      end
      2'd1: begin
        cmd.x_code = lspf_pkg::entry_code(2'd2, c1, col);
        cmd.y_code = lspf_pkg::entry_code(2'd1, c2, col);
      end
      default: begin
        cmd.x_code = lspf_pkg::E_N;
        cmd.y_code = lspf_pkg::entry_code(2'd0, k, col);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k      <= '0;
      p      <= '0;
      col    <= lspf_pkg::COL_NONE;
      status <= lspf_pkg::ST_OK;
      bitcnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && last_atom) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          k   <= '0;
          p   <= '0;
          col <= lspf_pkg::COL_NONE;
          if (stat.ovf) begin
            status <= lspf_pkg::ST_OVERFLOW;
            state  <= S_EMIT;
          end else begin
            state <= S_MLOAD;
          end
        end
        S_MLOAD: begin
          bitcnt <= '0;
          state  <= S_MSTEP;
        end
        S_MSTEP: begin
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == C_W'(SUM2_W - 1)) begin
            state <= S_MCOMMIT;
          end
        end
        S_MCOMMIT: begin
          if (p == 2'd2) begin
            p <= '0;
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_DETDONE;
            end else begin
              k     <= k + 1'b1;
              state <= S_MLOAD;
            end
          end else begin
            p     <= p + 1'b1;
            state <= S_MLOAD;
          end
        end
        S_DETDONE: begin
          if (col == lspf_pkg::COL_NONE) begin
            if (stat.det_zero) begin
              status <= lspf_pkg::ST_SINGULAR;
              state  <= S_EMIT;
            end else begin
              col   <= 2'd0;
              state <= S_MLOAD;
            end
          end else begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          bitcnt <= '0;
          state  <= S_DSTEP;
        end
        S_DSTEP: begin
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == C_W'(WW - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (col == 2'd2) begin
            status <= lspf_pkg::ST_OK;
            state  <= S_EMIT;
          end else begin
            col   <= col + 1'b1;
            state <= S_MLOAD;
          end
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/least_squares_plane_fit_top.sv */
// Least-squares plane fit z = a*x + b*y + c over the atoms of one residue.
// Uses lspf_pkg, lspf_ctrl and lspf_datapath.
//
// Usage: drive atom and raise start; an atom transaction is taken at a clock
// edge with start high and busy low. Busy stays low while atoms that are
// not last are taken, so one atom per cycle is accepted. The atom marked
// last_atom starts the solve: busy rises and the four determinants are
// built on a bit-serial multiplier (36 products, SUM2_W = 40 +
// clog2(MAX_ATOMS + 1)), then three restoring divisions run at one quotient
// bit per cycle (WW = 3 * SUM2_W + 18). An overflowed residue skips the
// determinants, and a singular one finishes after the first determinant.
// The result is shown for one cycle with done high; the receiver cannot
// stall and must take it then. Sums clear after each result. Reset (rst,
// synchronous) clears sums, counters and the controller to idle.
module least_squares_plane_fit_top #(
  parameter int MAX_ATOMS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lspf_pkg::atom_t atom,
  output logic            done,
  output lspf_pkg::fit_t  result
);

  lspf_pkg::cmd_t  cmd;
  lspf_pkg::stat_t stat;

  lspf_ctrl #(.MAX_ATOMS(MAX_ATOMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_atom (atom.last_atom),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  lspf_datapath #(.MAX_ATOMS(MAX_ATOMS)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .atom   (atom),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

/* dv/least_squares_plane_fit_top_tb.sv */
// Self-checking testbench for least_squares_plane_fit_top: directed table then random residues.
// Predicts each fit with exact wide integer Cramer solve; depends on lspf_pkg and the RTL.
`timescale 1ns / 100ps
module least_squares_plane_fit_top_tb;

  localparam int MAX_ATOMS = 64;
  localparam int WDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 3000;

  typedef logic signed [255:0] big_t;

  typedef struct {
    lspf_pkg::atom_t a;
    bit              typed;
    lspf_pkg::fit_t  want;
  } row_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  lspf_pkg::atom_t atom;
  logic            done;
  lspf_pkg::fit_t  result;

  least_squares_plane_fit_top #(.MAX_ATOMS(MAX_ATOMS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .atom(atom), .done(done), .result(result)
  );

  big_t acc_x, acc_y, acc_z, acc_xx, acc_yy, acc_xy, acc_xz, acc_yz;
  int   acc_n;
  bit   acc_ovf;
  lspf_pkg::fit_t pending_fits[$];
  int   errors;
  int   idle_cycles;
  int   idle_pct;
  int   atoms_sent;
  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic big_t det3(big_t a00, big_t a01, big_t a02, big_t a10, big_t a11,
                                big_t a12, big_t a20, big_t a21, big_t a22);
    return a00 * (a11 * a22 - a12 * a21) - a01 * (a10 * a22 - a12 * a20)
           + a02 * (a10 * a21 - a11 * a20);
  endfunction

  // round to nearest, ties away from zero, saturate to 32 bits
  function automatic logic [31:0] round_div_sat(big_t num, big_t den);
    big_t n, d, q;
    bit   neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q >= big_t'(64'h8000_0000)) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > big_t'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic lspf_pkg::fit_t zero_fit(logic [1:0] st);
    lspf_pkg::fit_t f;
    f = '0;
    f.fit_status = st;
    return f;
  endfunction

  task automatic clear_sums();
    {acc_x, acc_y, acc_z, acc_xx, acc_yy, acc_xy, acc_xz, acc_yz} = '0;
    acc_n = 0;
    acc_ovf = 1'b0;
  endtask

  task automatic absorb_atom(input lspf_pkg::atom_t a, output bit has_fit,
                             output lspf_pkg::fit_t f);
    big_t x, y, z, n, det;
    x = $signed(a.coord_x);
    y = $signed(a.coord_y);
    z = $signed(a.coord_z);
    has_fit = 1'b0;
    f = '0;
    if (acc_n < MAX_ATOMS) begin
      acc_x += x; acc_y += y; acc_z += z;
      acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
      acc_xz += x * z; acc_yz += y * z;
      acc_n++;
    end else begin
      acc_ovf = 1'b1;
    end
    if (!a.last_atom) return;
    has_fit = 1'b1;
    n = acc_n;
    det = det3(acc_xx, acc_xy, acc_x, acc_xy, acc_yy, acc_y, acc_x, acc_y, n);
    if (acc_ovf) f = zero_fit(lspf_pkg::ST_OVERFLOW);
    else if (det == 0) f = zero_fit(lspf_pkg::ST_SINGULAR);
    else begin
      f.fit_status = lspf_pkg::ST_OK;
      f.slope_x = round_div_sat(det3(acc_xz, acc_xy, acc_x, acc_yz, acc_yy, acc_y,
                                     acc_z, acc_y, n) * 65536, det);
      f.slope_y = round_div_sat(det3(acc_xx, acc_xz, acc_x, acc_xy, acc_yz, acc_y,
                                     acc_x, acc_z, n) * 65536, det);
      f.offset = round_div_sat(det3(acc_xx, acc_xy, acc_xz, acc_xy, acc_yy, acc_yz,
                                    acc_x, acc_y, acc_z) * 256, det);
    end
    clear_sums();
  endtask

  function automatic lspf_pkg::atom_t mk_atom(int x, int y, int z, bit last);
    lspf_pkg::atom_t a;
    a.coord_x = x[19:0];
    a.coord_y = y[19:0];
    a.coord_z = z[19:0];
    a.last_atom = last;
    return a;
  endfunction

  task automatic add_row(lspf_pkg::atom_t a, bit typed = 0, lspf_pkg::fit_t want = '0);
    row_t r;
    r.a = a;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // one atom transaction; typed expectation overrides the prediction
  task automatic send_atom(lspf_pkg::atom_t a, bit typed = 0, lspf_pkg::fit_t want = '0);
    bit             has_fit;
    lspf_pkg::fit_t f;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    atom <= a;
    do @(posedge clk); while (busy);
    atoms_sent++;
    absorb_atom(a, has_fit, f);
    if (has_fit) pending_fits.push_back(typed ? want : f);
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($urandom_range(1048575)) - 524288;
      1: return int'($urandom_range(2047)) - 1024;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic send_residue();
    int len, mode, kind, ca, cb, cc, x, y, z, vx;
    kind = $urandom_range(99);
    if (kind < 4) len = $urandom_range(2, 1);
    else if (kind < 7) len = $urandom_range(70, MAX_ATOMS);
    else len = $urandom_range(12, 3);
    mode = $urandom_range(2);
    ca = int'($urandom_range(8)) - 4;
    cb = int'($urandom_range(8)) - 4;
    cc = rand_coord(1) * 64;
    vx = rand_coord(mode);
    for (int i = 0; i < len; i++) begin
      x = rand_coord(mode);
      y = rand_coord(mode);
      z = rand_coord(mode);
      if (kind >= 7 && kind < 45) z = ca * x / 8 + cb * y / 8 + cc + int'($urandom_range(6)) - 3;
      else if (kind >= 45 && kind < 52) x = vx;
      if (z > 524287) z = 524287;
      if (z < -524288) z = -524288;
      if (kind >= 97 && i == 0) send_atom(mk_atom(x, y, z, 1'($urandom_range(1))));
      send_atom(mk_atom(x, y, z, i == len - 1));
    end
  endtask

  task automatic drain();
    while (pending_fits.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (done) begin
        if (pending_fits.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, result);
          errors++;
        end else begin
          lspf_pkg::fit_t w;
          w = pending_fits.pop_front();
          if (result.slope_x !== w.slope_x)
            $display("%0t: slope_x expected %h actual %h", $time, w.slope_x, result.slope_x);
          if (result.slope_y !== w.slope_y)
            $display("%0t: slope_y expected %h actual %h", $time, w.slope_y, result.slope_y);
          if (result.offset !== w.offset)
            $display("%0t: offset expected %h actual %h", $time, w.offset, result.offset);
          if (result.fit_status !== w.fit_status)
            $display("%0t: fit_status expected %0d actual %0d", $time, w.fit_status,
                     result.fit_status);
          if (result !== w) errors++;
        end
      end
    end
  end

  initial begin
    lspf_pkg::fit_t plane;
    int             sent;
    int             before_n;
    errors = 0;
    idle_pct = 0;
    atoms_sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    atom <= '0;
    clear_sums();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plane = '0;
    plane.slope_x = 32'sd65536;
    add_row(mk_atom(0, 0, 0, 1), 1, zero_fit(lspf_pkg::ST_SINGULAR));
    add_row(mk_atom(524287, -524288, 524287, 0));
    add_row(mk_atom(-524288, 524287, -524288, 1), 1, zero_fit(lspf_pkg::ST_SINGULAR));
    add_row(mk_atom(0, 0, 0, 0));
    add_row(mk_atom(256, 0, 256, 0));
    add_row(mk_atom(0, 256, 0, 1), 1, plane);
    add_row(mk_atom(524287, 524287, 524287, 0));
    add_row(mk_atom(-524288, 0, -524288, 0));
    add_row(mk_atom(0, -524288, 524287, 1));
    add_row(mk_atom(100, 200, 5, 0));
    add_row(mk_atom(100, 200, -7, 0));
    add_row(mk_atom(100, 200, 900, 1), 1, zero_fit(lspf_pkg::ST_SINGULAR));
    add_row(mk_atom(50, 0, 1, 0));
    add_row(mk_atom(50, 10, 2, 0));
    add_row(mk_atom(50, -30, 3, 1), 1, zero_fit(lspf_pkg::ST_SINGULAR));
    add_row(mk_atom(-3, 7, 11, 0));
    add_row(mk_atom(1, 1, 1, 0));
    add_row(mk_atom(-1, -1, 1, 0));
    add_row(mk_atom(1, -1, -1, 1));
    foreach (dir_rows[i]) send_atom(dir_rows[i].a, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : (ph == 1) ? 66 : 0;
      sent = 0;
      while (sent < 550) begin
        before_n = atoms_sent;
        send_residue();
        sent += atoms_sent - before_n;
      end
      start <= 1'b0;
      drain();
    end

    start <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
